@@ rtl/core/pli_pkg.sv @@
// Shared constants and codes for the piecewise linear interpolator.
// Holds table geometry, field widths and the item action codes.
// No dependencies; used by every file of the core.
package pli_pkg;

    // Breakpoint table geometry.
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int IDX_W      = 11;
    localparam int DATA_W     = 30;
    localparam int ENTRY_W    = 2 * DATA_W;

    // Number of restoring divide steps, one per quotient bit.
    localparam int DIV_STEPS  = DATA_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Action codes of an input word.
    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

endpackage

@@ rtl/core/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator: load breakpoints, then query a position. Depends on pli_pkg.
// A load is written in its accepting cycle. A query of 0 or with no points goes straight to
// the finish state, and a query past the last breakpoint k returns the time of breakpoint k
// after the scan. Any other query scans to the first greater breakpoint, reads the left
// neighbor (skipped for breakpoint 1), then runs set-up, multiply and 30 divide steps.
// The block takes one word at a time. Reset clears control and sets point_count to 1 only.
module piecewise_linear_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port for point_count.
    input  logic                          cfg_wr_en,
    input  logic [pli_pkg::IDX_W-1:0]     cfg_wr_data,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [pli_pkg::IDX_W-1:0]     point_index,
    input  logic [pli_pkg::DATA_W-1:0]    point_position,
    input  logic [pli_pkg::DATA_W-1:0]    point_time,
    input  logic [pli_pkg::DATA_W-1:0]    query_position,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pli_pkg::DATA_W-1:0]    interpolated_time
);

    localparam int AW = pli_pkg::ADDR_W;
    localparam int IW = pli_pkg::IDX_W;
    localparam int DW = pli_pkg::DATA_W;
    localparam int EW = pli_pkg::ENTRY_W;
    localparam int CW = pli_pkg::CNT_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SRCH = 8'b0000_0010,
        ST_SCMP = 8'b0000_0100,
        ST_RD_L = 8'b0000_1000,
        ST_DIFF = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    // Breakpoint table: {position, time} per entry, one read and one write port.
    logic [EW-1:0] table_mem [pli_pkg::MAX_POINTS];

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data_reg;
    logic [DW-1:0] rd_pos;
    logic [DW-1:0] rd_time;

    state_t        state_reg, state_next;
    logic [IW-1:0] point_count_reg;
    logic [IW-1:0] k_clamp;
    logic [IW-1:0] k_reg, k_next;
    logic [DW-1:0] q_reg, q_next;
    logic [IW-1:0] mid_reg, mid_next;
    logic [DW-1:0] pl_reg, pl_next;
    logic [DW-1:0] pr_reg, pr_next;
    logic [DW-1:0] tl_reg, tl_next;
    logic [DW-1:0] tr_reg, tr_next;
    logic [DW-1:0] dq_reg, dq_next;
    logic [DW-1:0] dp_reg, dp_next;
    logic [DW-1:0] dt_reg, dt_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          direct_reg, direct_next;
    logic [DW-1:0] direct_val_reg, direct_val_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] result_reg, result_next;

    logic [EW-1:0] product;
    logic [DW:0]   trial;
    logic          trial_ge;
    logic [DW:0]   up_sum;
    logic [DW:0]   down_mag;
    logic [DW-1:0] final_val;

    assign rd_pos  = rd_data_reg[EW-1:DW];
    assign rd_time = rd_data_reg[DW-1:0];

    // Point count in use, limited to the table depth.
    assign k_clamp = (point_count_reg > IW'(pli_pkg::MAX_POINTS)) ?
                     IW'(pli_pkg::MAX_POINTS) : point_count_reg;

    // Table address of a load; index 0 and indexes past the table are dropped.
    assign wr_addr = AW'(point_index - IW'(1));

    // One restoring divide step on the partial remainder.
    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign trial_ge = (trial >= {1'b0, dp_reg});

    assign product = dq_reg * dt_reg;

    // Final value: tl plus the floor quotient, or tl minus the ceiling quotient, clamped to the field.
    assign up_sum   = {1'b0, tl_reg} + {1'b0, quo_reg};
    assign down_mag = {1'b0, quo_reg} + {{DW{1'b0}}, (rem_reg != '0)};
    always_comb
    begin
        if (neg_reg)
        begin
            if (down_mag > {1'b0, tl_reg})
                final_val = '0;
            else
                final_val = tl_reg - down_mag[DW-1:0];
        end
        else
        begin
            if (up_sum[DW])
                final_val = {DW{1'b1}};
            else
                final_val = up_sum[DW-1:0];
        end
    end

    // Sequencer for loads, scan, fetch, multiply and divide.
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        q_next          = q_reg;
        mid_next        = mid_reg;
        pl_next         = pl_reg;
        pr_next         = pr_reg;
        tl_next         = tl_reg;
        tr_next         = tr_reg;
        dq_next         = dq_reg;
        dp_next         = dp_reg;
        dt_next         = dt_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        direct_next     = direct_reg;
        direct_val_next = direct_val_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == pli_pkg::ACT_QUERY)
                    begin
                        q_next = query_position;
                        k_next = k_clamp;
                        if (query_position == '0 || k_clamp == '0)
                        begin
                            direct_next     = 1'b1;
                            direct_val_next = '0;
                            state_next      = ST_FIN;
                        end
                        else
                        begin
                            direct_next = 1'b0;
                            state_next  = ST_SRCH;
                        end
                    end
                    else
                    begin
                        wr_en = (point_index != '0) &&
                                (point_index <= IW'(pli_pkg::MAX_POINTS));
                    end
                end
            end
            ST_SRCH:
            begin
                // Start the scan at breakpoint 1.
                rd_en      = 1'b1;
                rd_addr    = '0;
                mid_next   = IW'(1);
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                if (rd_pos > q_reg)
                begin
                    // First breakpoint past the query is the right neighbor.
                    pr_next = rd_pos;
                    tr_next = rd_time;
                    if (mid_reg == IW'(1))
                    begin
                        // Left neighbor is the origin.
                        pl_next    = '0;
                        tl_next    = '0;
                        state_next = ST_DIFF;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(mid_reg - IW'(2));
                        state_next = ST_RD_L;
                    end
                end
                else if (mid_reg == k_reg)
                begin
                    // No breakpoint lies past the query: return the last time.
                    direct_next     = 1'b1;
                    direct_val_next = rd_time;
                    state_next      = ST_FIN;
                end
                else
                begin
                    // Fetch the next breakpoint while this one is compared.
                    rd_en    = 1'b1;
                    rd_addr  = AW'(mid_reg);
                    mid_next = mid_reg + IW'(1);
                end
            end
            ST_RD_L:
            begin
                pl_next    = rd_pos;
                tl_next    = rd_time;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dq_next    = q_reg - pl_reg;
                dp_next    = pr_reg - pl_reg;
                neg_next   = (tr_reg < tl_reg);
                dt_next    = (tr_reg < tl_reg) ? (tl_reg - tr_reg) : (tr_reg - tl_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                rem_next   = product[EW-1:DW];
                quo_next   = product[DW-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (trial_ge)
                    rem_next = DW'(trial - {1'b0, dp_reg});
                else
                    rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], trial_ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(pli_pkg::DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = direct_reg ? direct_val_reg : final_val;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= {point_position, point_time};
        if (rd_en)
            rd_data_reg <= table_mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= IW'(1);
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
                point_count_reg <= cfg_wr_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        q_reg          <= q_next;
        mid_reg        <= mid_next;
        pl_reg         <= pl_next;
        pr_reg         <= pr_next;
        tl_reg         <= tl_next;
        tr_reg         <= tr_next;
        dq_reg         <= dq_next;
        dp_reg         <= dp_next;
        dt_reg         <= dt_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        direct_reg     <= direct_next;
        direct_val_reg <= direct_val_next;
        result_reg     <= result_next;
    end

    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign interpolated_time = result_reg;

    // An accepted query keeps the input side stalled in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == pli_pkg::ACT_QUERY) |=> in_stall)
        else $error("query accepted but input not stalled");

    // The scan only compares breakpoints 1..k.
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCMP) |-> (mid_reg != '0 && mid_reg <= k_reg))
        else $error("scan index out of range");

    // A new result word appears only out of the finish state.
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FIN))
        else $error("result word raised outside finish state");

endmodule

@@ bench/tb_piecewise_linear_interpolator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise linear interpolator: loads breakpoint
// tables, queries positions and checks each time against a built-in predictor.
// Depends on pli_pkg and the piecewise_linear_interpolator top level.
module tb_piecewise_linear_interpolator;

    localparam int                DATA_W       = pli_pkg::DATA_W;
    localparam int                IDX_W        = pli_pkg::IDX_W;
    localparam int                MAX_POINTS   = pli_pkg::MAX_POINTS;
    localparam int                CLK_HALF     = 2;
    localparam int                RESET_CYCLES = 11;
    localparam int                DRAIN_CYCLES = 80;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                CYCLE_LIMIT  = 20000000;
    localparam int                REPORT_LIMIT = 200;
    localparam logic [DATA_W-1:0] FULL_SCALE   = '1;

    // Shapes of a generated breakpoint table.
    typedef enum int {
        SHAPE_SORTED,
        SHAPE_FREE_TIME,
        SHAPE_UNSORTED
    } table_shape_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic                action;
    logic [IDX_W-1:0]    point_index;
    logic [DATA_W-1:0]   point_position;
    logic [DATA_W-1:0]   point_time;
    logic [DATA_W-1:0]   query_position;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DATA_W-1:0]   interpolated_time;

    // Predictor state: breakpoints 1..MAX_POINTS and the active count.
    logic [DATA_W-1:0]   knot_pos  [1:MAX_POINTS];
    logic [DATA_W-1:0]   knot_time [1:MAX_POINTS];
    logic [IDX_W-1:0]    active_count;

    logic [DATA_W-1:0]   expected_times [$];
    int                  fail_count    = 0;
    int                  cycle_count   = 0;
    bit                  gaps_on       = 1'b1;
    bit                  stalls_on     = 1'b1;
    int                  hold_requests = 0;
    int                  hold_seen     = 0;
    int                  hold_left     = 0;
    int                  stall_left    = 0;

    piecewise_linear_interpolator i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .point_index       (point_index),
        .point_position    (point_position),
        .point_time        (point_time),
        .query_position    (query_position),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .interpolated_time (interpolated_time)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_idle_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return $urandom_range(1, 3);
        else if (sel < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Breakpoint 0 is the origin; the others come from the tables.
    function automatic logic [DATA_W-1:0] knot_pos_at(int i);
        return (i == 0) ? '0 : knot_pos[i];
    endfunction

    function automatic logic [DATA_W-1:0] knot_time_at(int i);
        return (i == 0) ? '0 : knot_time[i];
    endfunction

    function automatic int clamped_count();
        return (active_count > MAX_POINTS) ? MAX_POINTS : int'(active_count);
    endfunction

    // Time at a queried position: first-greater scan, then floor interpolation.
    function automatic logic [DATA_W-1:0] predict_time(logic [DATA_W-1:0] q);
        int                  k;
        int                  r;
        int                  i;
        bit                  found;
        logic [DATA_W-1:0]   pl;
        logic [DATA_W-1:0]   pr;
        logic [DATA_W-1:0]   tl;
        logic [DATA_W-1:0]   tr;
        longint unsigned     dq;
        longint unsigned     dp;
        longint unsigned     mag;
        longint unsigned     quo;
        longint              res;
        k = clamped_count();
        if (q == 0)
            return '0;
        found = 1'b0;
        r = 0;
        for (i = 0; i <= k && !found; i++)
        begin
            if (knot_pos_at(i) > q)
            begin
                r = i;
                found = 1'b1;
            end
        end
        if (!found)
            return knot_time_at(k);
        pl = knot_pos_at(r - 1);
        pr = knot_pos_at(r);
        tl = knot_time_at(r - 1);
        tr = knot_time_at(r);
        dq = longint'(q) - longint'(pl);
        dp = longint'(pr) - longint'(pl);
        if (tr >= tl)
        begin
            quo = (dq * longint'(tr - tl)) / dp;
            res = longint'(tl) + longint'(quo);
        end
        else
        begin
            // Ceiling of the magnitude gives the floor of a falling step.
            mag = dq * longint'(tl - tr);
            quo = (mag + dp - 1) / dp;
            res = longint'(tl) - longint'(quo);
        end
        if (res < 0)
            res = 0;
        if (res > longint'(FULL_SCALE))
            res = longint'(FULL_SCALE);
        return res[DATA_W-1:0];
    endfunction

    // Offers one word, holds it until accepted, updates the predictor, then may idle for a gap.
    task automatic send_word(pli_pkg::action_t act, logic [IDX_W-1:0] idx,
                             logic [DATA_W-1:0] pos, logic [DATA_W-1:0] tim,
                             logic [DATA_W-1:0] q);
        int gap;
        in_valid       <= 1'b1;
        action         <= act;
        point_index    <= idx;
        point_position <= pos;
        point_time     <= tim;
        query_position <= q;
        do
            @(posedge clk);
        while (in_stall);
        if (act == pli_pkg::ACT_LOAD)
        begin
            if (idx >= 1 && idx <= MAX_POINTS)
            begin
                knot_pos[idx]  = pos;
                knot_time[idx] = tim;
            end
        end
        else
            expected_times = {expected_times, predict_time(q)};
        if (gaps_on && $urandom_range(0, 99) < 35)
        begin
            gap = pick_idle_len();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_load(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] pos,
                             logic [DATA_W-1:0] tim);
        send_word(pli_pkg::ACT_LOAD, idx, pos, tim, DATA_W'($urandom()));
    endtask

    task automatic send_query(logic [DATA_W-1:0] q);
        send_word(pli_pkg::ACT_QUERY, IDX_W'($urandom()), DATA_W'($urandom()),
                  DATA_W'($urandom()), q);
    endtask

    function automatic logic [IDX_W-1:0] pick_bad_index();
        return $urandom_range(0, 1) ? IDX_W'(0) : IDX_W'($urandom_range(MAX_POINTS + 1, 2047));
    endfunction

    // Stops offering words and waits until the block has gone quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_point_count(logic [IDX_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        active_count  = value;
    endtask

    // Step between neighboring breakpoints: zero, small, medium, or up to full scale divided by n.
    function automatic longint pick_step(int n);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return 0;
        else if (sel < 50)
            return $urandom_range(1, 16);
        else if (sel < 85)
            return $urandom_range(1, 1 << 20);
        else
            return $urandom_range(1, int'(FULL_SCALE) / n);
    endfunction

    // Writes breakpoints 1..n with the given shape, with a few ignored loads mixed in.
    task automatic load_table(int n, table_shape_t shape);
        longint              p;
        longint              t;
        int                  j;
        logic [DATA_W-1:0]   pos;
        logic [DATA_W-1:0]   tim;
        p = 0;
        t = 0;
        for (j = 1; j <= n; j++)
        begin
            p = p + pick_step(n);
            if (p > longint'(FULL_SCALE))
                p = longint'(FULL_SCALE);
            t = t + pick_step(n);
            if (t > longint'(FULL_SCALE))
                t = longint'(FULL_SCALE);
            pos = p[DATA_W-1:0];
            tim = t[DATA_W-1:0];
            if (shape == SHAPE_UNSORTED)
                pos = $urandom_range(0, 1) ? DATA_W'($urandom()) : DATA_W'($urandom_range(0, 1000));
            if (shape != SHAPE_SORTED)
                tim = DATA_W'($urandom());
            if ($urandom_range(0, 99) < 5)
                send_load(pick_bad_index(), DATA_W'($urandom()), DATA_W'($urandom()));
            send_load(IDX_W'(j), pos, tim);
        end
    endtask

    // Query position: zero, near a breakpoint, above or below the highest position, or random.
    function automatic logic [DATA_W-1:0] pick_query();
        int                  k;
        int                  j;
        int                  sel;
        logic [DATA_W-1:0]   top;
        longint              v;
        k = clamped_count();
        top = '0;
        for (j = 1; j <= k; j++)
            if (knot_pos[j] > top)
                top = knot_pos[j];
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return '0;
        if (sel < 40 && k > 0)
        begin
            j = $urandom_range(1, k);
            v = longint'(knot_pos[j]) + $urandom_range(0, 2) - 1;
            if (v < 0)
                v = 0;
            if (v > longint'(FULL_SCALE))
                v = longint'(FULL_SCALE);
            return v[DATA_W-1:0];
        end
        if (sel < 50)
            return DATA_W'($urandom_range(top, FULL_SCALE));
        if (sel < 90)
            return DATA_W'($urandom_range(0, top));
        return DATA_W'($urandom());
    endfunction

    // Edges of the fields, the origin, duplicate and unsorted positions,
    // falling time steps, ignored loads and a point count of zero.
    task automatic test_directed_cases();
        send_load(IDX_W'(1), DATA_W'(100), DATA_W'(1000));
        send_load(IDX_W'(2), DATA_W'(100), DATA_W'(2000));
        send_load(IDX_W'(3), DATA_W'(300), DATA_W'(500));
        send_load(IDX_W'(4), FULL_SCALE, FULL_SCALE);
        send_load(IDX_W'(0), DATA_W'(5), DATA_W'(7));
        send_load(IDX_W'(MAX_POINTS + 1), DATA_W'(1), DATA_W'(1));
        send_load('1, FULL_SCALE, FULL_SCALE);
        wait_idle();
        set_point_count(IDX_W'(4));
        send_query(DATA_W'(0));
        send_query(DATA_W'(1));
        send_query(DATA_W'(99));
        send_query(DATA_W'(100));
        send_query(DATA_W'(101));
        send_query(DATA_W'(200));
        send_query(DATA_W'(299));
        send_query(DATA_W'(300));
        send_query(FULL_SCALE - 1);
        send_query(FULL_SCALE);
        wait_idle();
        set_point_count(IDX_W'(0));
        send_query(DATA_W'(5));
        send_query(FULL_SCALE);
        wait_idle();
        set_point_count(IDX_W'(2));
        send_query(DATA_W'(150));
        send_query(DATA_W'(100));
        // A lower position after a higher one: the scan stops at the first greater.
        send_load(IDX_W'(2), DATA_W'(50), DATA_W'(7));
        wait_idle();
        set_point_count(IDX_W'(4));
        send_query(DATA_W'(75));
        send_query(DATA_W'(120));
        wait_idle();
    endtask

    // Fills every entry, then runs the largest, out-of-range and single-point counts.
    task automatic test_full_table();
        int i;
        gaps_on = 1'b0;
        load_table(MAX_POINTS, SHAPE_SORTED);
        gaps_on = 1'b1;
        wait_idle();
        set_point_count(IDX_W'(MAX_POINTS));
        for (i = 0; i < 120; i++)
            send_query(pick_query());
        wait_idle();
        set_point_count('1);
        for (i = 0; i < 60; i++)
            send_query(pick_query());
        wait_idle();
        set_point_count(IDX_W'(1));
        for (i = 0; i < 20; i++)
            send_query(pick_query());
        wait_idle();
    endtask

    // The receiver holds off while queries keep coming, then the sender
    // pauses until every result is back and then sends more queries.
    task automatic test_backpressure();
        int i;
        set_point_count(IDX_W'(16));
        gaps_on = 1'b0;
        hold_requests++;
        for (i = 0; i < 40; i++)
            send_query(pick_query());
        gaps_on = 1'b1;
        in_valid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge clk);
        for (i = 0; i < 20; i++)
            send_query(pick_query());
        wait_idle();
    endtask

    // Many small tables of random shape, with loads mixed into the query stream.
    task automatic test_random_tables();
        int             phase;
        int             n;
        int             nq;
        int             i;
        int             sel;
        table_shape_t   shape;
        for (phase = 0; phase < 20; phase++)
        begin
            gaps_on   = ($urandom_range(0, 4) != 0);
            stalls_on = ($urandom_range(0, 4) != 0);
            sel = $urandom_range(0, 99);
            n = (sel < 70) ? $urandom_range(1, 8) : $urandom_range(9, 64);
            sel = $urandom_range(0, 99);
            shape = (sel < 75) ? SHAPE_SORTED : (sel < 85) ? SHAPE_FREE_TIME : SHAPE_UNSORTED;
            load_table(n, shape);
            wait_idle();
            // Every entry is written by now, so any count is safe.
            sel = $urandom_range(0, 99);
            if (sel < 70)
                set_point_count(IDX_W'(n));
            else if (sel < 80)
                set_point_count(IDX_W'(0));
            else if (sel < 85)
                set_point_count(IDX_W'(MAX_POINTS));
            else if (sel < 90)
                set_point_count('1);
            else
                set_point_count(IDX_W'($urandom()));
            nq = $urandom_range(15, 40);
            for (i = 0; i < nq; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 5)
                    send_load(IDX_W'($urandom_range(1, n)), DATA_W'($urandom()),
                              DATA_W'($urandom()));
                else if (sel < 8)
                    send_load(pick_bad_index(), DATA_W'($urandom()), DATA_W'($urandom()));
                else
                    send_query(pick_query());
            end
            wait_idle();
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Result check and receiver stall; a long hold-off is counted here.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_times.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected word, expected none, actual %0d",
                             $time, interpolated_time);
            end
            else if (interpolated_time !== expected_times[0])
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: interpolated_time mismatch, expected %0d, actual %0d",
                             $time, expected_times[0], interpolated_time);
                void'(expected_times.pop_front());
            end
            else
                void'(expected_times.pop_front());
        end
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stalls_on && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_idle_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        in_valid       <= 1'b0;
        action         <= pli_pkg::ACT_LOAD;
        point_index    <= '0;
        point_position <= '0;
        point_time     <= '0;
        query_position <= '0;
        active_count    = IDX_W'(1);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_full_table();
        test_backpressure();
        test_random_tables();
        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
